/* design/dual_range_sensor_step_judge_macros.svh */
// Assertion helpers used by dual_range_sensor_step_judge.sv.
`ifndef DUAL_RANGE_SENSOR_STEP_JUDGE_MACROS_SVH
`define DUAL_RANGE_SENSOR_STEP_JUDGE_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define DRSSJ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define DRSSJ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/drssj_pkg.sv */
package drssj_pkg;

    localparam int NOW_W       = 32;
    localparam int FRAME_W     = 32;
    localparam int DIST_W      = 16;
    localparam int CLASS_W     = 2;
    localparam int RUN_W       = 8;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ASSIST_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DESCEND_MODE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_LOWER    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STALE_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STABLE_COUNT  = 3'd4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;
    localparam logic [RUN_W-1:0]     STABLE_RESET  = 8'd1;

    localparam logic [CLASS_W-1:0] FRONT_INVALID = 2'd0;
    localparam logic [CLASS_W-1:0] FRONT_FAR     = 2'd1;
    localparam logic [CLASS_W-1:0] FRONT_NEAR    = 2'd2;
    localparam logic [CLASS_W-1:0] FRONT_EDGE    = 2'd3;

    localparam logic [CLASS_W-1:0] LEG_INVALID = 2'd0;
    localparam logic [CLASS_W-1:0] LEG_STEP    = 2'd1;
    localparam logic [CLASS_W-1:0] LEG_GROUND  = 2'd2;
    localparam logic [CLASS_W-1:0] LEG_HIGH    = 2'd3;

    localparam logic signed [DIST_W-1:0] FRONT_NEAR_LO    = 16'sd430;
    localparam logic signed [DIST_W-1:0] FRONT_NEAR_HI    = 16'sd500;
    localparam logic signed [DIST_W-1:0] FRONT_EDGE_LO    = 16'sd800;
    localparam logic signed [DIST_W-1:0] AUTO_LOWER_LO    = 16'sd950;
    localparam logic signed [DIST_W-1:0] AUTO_LOWER_HI    = 16'sd1120;
    localparam logic signed [DIST_W-1:0] DESCEND_LOWER_LO = 16'sd1650;
    localparam logic signed [DIST_W-1:0] DESCEND_LOWER_HI = 16'sd1700;
    localparam logic signed [DIST_W-1:0] LEG_STEP_LO      = 16'sd0;
    localparam logic signed [DIST_W-1:0] LEG_STEP_HI      = 16'sd449;
    localparam logic signed [DIST_W-1:0] LEG_GROUND_LO    = 16'sd450;
    localparam logic signed [DIST_W-1:0] LEG_GROUND_HI    = 16'sd800;
    localparam logic signed [DIST_W-1:0] LEG_HIGH_LO      = 16'sd801;
    localparam logic signed [DIST_W-1:0] LEG_HIGH_HI      = 16'sd1400;

    typedef struct packed {
        logic [NOW_W-1:0]         now_ms;
        logic                     front_valid;
        logic                     front_fault;
        logic signed [DIST_W-1:0] front_distance_mm;
        logic [FRAME_W-1:0]       front_frame_num;
        logic                     leg_valid;
        logic                     leg_fault;
        logic signed [DIST_W-1:0] leg_distance_mm;
        logic [FRAME_W-1:0]       leg_frame_num;
    } in_item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] front_class;
        logic [CLASS_W-1:0] leg_class;
        logic               front_is_fresh;
        logic               leg_is_fresh;
        logic               suggest_climb;
        logic               suggest_descent;
        logic               suggest_edge_ready;
        logic               lower_after_climb;
        logic               lower_after_descend;
        logic               saw_high_latched;
        logic               saw_close_latched;
    } out_item_t;

    typedef struct packed {
        logic                 assist_enable;
        logic                 descend_mode;
        logic                 auto_lower_enable;
        logic [TIMEOUT_W-1:0] stale_timeout_ms;
        logic [RUN_W-1:0]     stable_count;
        logic                 clr_progress;
        logic                 clr_lower;
    } ctl_t;

endpackage

/* design/drssj_chan_if.sv */
interface drssj_chan_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

/* design/drssj_track.sv */
module drssj_track
    import drssj_pkg::*;
#(
    parameter int TICK_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [TICK_WIDTH-1:0] now,
    input  logic                  valid,
    input  logic                  fault,
    input  logic [FRAME_W-1:0]    frame,
    input  logic [TIMEOUT_W-1:0]  timeout,
    output logic                  fresh
);

    logic [FRAME_W-1:0]    last_frame_reg;
    logic [TICK_WIDTH-1:0] last_change_reg;
    logic                  changed;
    logic [TICK_WIDTH-1:0] age;

    // A new frame number restarts the age at zero on this very tick.
    assign changed = (frame != last_frame_reg);
    assign age     = changed ? '0 : (now - last_change_reg);
    assign fresh   = valid && !fault && (frame != '0) && (age <= TICK_WIDTH'(timeout));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_frame_reg  <= '0;
            last_change_reg <= '0;
        end
        else if (step && changed)
        begin
            last_frame_reg  <= frame;
            last_change_reg <= now;
        end
    end

endmodule

/* design/drssj_run.sv */
module drssj_run
    import drssj_pkg::*;
#(
    parameter int RUN_MAX = 255
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             match,
    input  logic             clr,
    output logic [RUN_W-1:0] upd
);

    logic [RUN_W-1:0] cnt_reg;

    always_comb
    begin
        if (!match)
            upd = '0;
        else if (cnt_reg < RUN_W'(RUN_MAX))
            upd = cnt_reg + 1'b1;
        else
            upd = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (clr)
            cnt_reg <= '0;
        else if (step)
            cnt_reg <= upd;
    end

endmodule

/* design/drssj_judge.sv */
module drssj_judge
    import drssj_pkg::*;
#(
    parameter int RUN_MAX = 255
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  ctl_t                     ctl,
    input  logic                     front_fresh,
    input  logic                     leg_fresh,
    input  logic signed [DIST_W-1:0] front_dist,
    input  logic signed [DIST_W-1:0] leg_dist,
    output out_item_t                res
);

    logic [CLASS_W-1:0] fclass;
    logic [CLASS_W-1:0] lclass;
    logic               auto_band;
    logic               descend_band;
    logic               clr_lower;
    logic               climb;
    logic [RUN_W-1:0]   near_upd;
    logic [RUN_W-1:0]   edge_upd;
    logic [RUN_W-1:0]   auto_upd;
    logic [RUN_W-1:0]   descend_upd;
    logic [RUN_W-1:0]   ground_upd;
    logic [RUN_W-1:0]   high_upd;
    logic [RUN_W-1:0]   step_upd;
    logic               high_seen_reg;
    logic               close_seen_reg;
    logic               high_seen_next;
    logic               close_seen_next;

    always_comb
    begin
        priority if (!front_fresh)
            fclass = FRONT_INVALID;
        else if (front_dist >= FRONT_EDGE_LO)
            fclass = FRONT_EDGE;
        else if (front_dist >= FRONT_NEAR_LO && front_dist <= FRONT_NEAR_HI)
            fclass = FRONT_NEAR;
        else
            fclass = FRONT_FAR;
    end

    always_comb
    begin
        priority if (!leg_fresh)
            lclass = LEG_INVALID;
        else if (leg_dist >= LEG_STEP_LO && leg_dist <= LEG_STEP_HI)
            lclass = LEG_STEP;
        else if (leg_dist >= LEG_GROUND_LO && leg_dist <= LEG_GROUND_HI)
            lclass = LEG_GROUND;
        else if (leg_dist >= LEG_HIGH_LO && leg_dist <= LEG_HIGH_HI)
            lclass = LEG_HIGH;
        else
            lclass = LEG_INVALID;
    end

    assign auto_band    = front_fresh && front_dist >= AUTO_LOWER_LO
                          && front_dist <= AUTO_LOWER_HI;
    assign descend_band = front_fresh && front_dist >= DESCEND_LOWER_LO
                          && front_dist <= DESCEND_LOWER_HI;

    // The lowering runs restart on a disabled tick and on progress or auto-lower writes.
    assign clr_lower = (step && !ctl.assist_enable) || ctl.clr_progress || ctl.clr_lower;
    assign climb     = !ctl.descend_mode;

    drssj_run #(.RUN_MAX(RUN_MAX)) u_near_run (
        .clk(clk), .rst_n(rst_n), .step(step), .match(fclass == FRONT_NEAR),
        .clr(1'b0), .upd(near_upd)
    );

    drssj_run #(.RUN_MAX(RUN_MAX)) u_edge_run (
        .clk(clk), .rst_n(rst_n), .step(step), .match(fclass == FRONT_EDGE),
        .clr(1'b0), .upd(edge_upd)
    );

    drssj_run #(.RUN_MAX(RUN_MAX)) u_auto_lower_run (
        .clk(clk), .rst_n(rst_n), .step(step), .match(auto_band),
        .clr(clr_lower), .upd(auto_upd)
    );

    drssj_run #(.RUN_MAX(RUN_MAX)) u_descend_lower_run (
        .clk(clk), .rst_n(rst_n), .step(step), .match(descend_band),
        .clr(clr_lower), .upd(descend_upd)
    );

    drssj_run #(.RUN_MAX(RUN_MAX)) u_ground_run (
        .clk(clk), .rst_n(rst_n), .step(step), .match(lclass == LEG_GROUND),
        .clr(1'b0), .upd(ground_upd)
    );

    drssj_run #(.RUN_MAX(RUN_MAX)) u_high_run (
        .clk(clk), .rst_n(rst_n), .step(step), .match(lclass == LEG_HIGH),
        .clr(1'b0), .upd(high_upd)
    );

    drssj_run #(.RUN_MAX(RUN_MAX)) u_step_run (
        .clk(clk), .rst_n(rst_n), .step(step), .match(lclass == LEG_STEP),
        .clr(1'b0), .upd(step_upd)
    );

    assign high_seen_next  = ctl.assist_enable
                             && (high_seen_reg || high_upd >= ctl.stable_count);
    assign close_seen_next = ctl.assist_enable
                             && (close_seen_reg || ground_upd >= ctl.stable_count
                                 || step_upd >= ctl.stable_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_seen_reg  <= 1'b0;
            close_seen_reg <= 1'b0;
        end
        else if (ctl.clr_progress)
        begin
            high_seen_reg  <= 1'b0;
            close_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            high_seen_reg  <= high_seen_next;
            close_seen_reg <= close_seen_next;
        end
    end

    always_comb
    begin
        res.front_class          = fclass;
        res.leg_class            = lclass;
        res.front_is_fresh       = front_fresh;
        res.leg_is_fresh         = leg_fresh;
        res.suggest_climb        = ctl.assist_enable && climb
                                   && near_upd >= ctl.stable_count;
        res.suggest_descent      = ctl.assist_enable && !climb
                                   && auto_upd >= ctl.stable_count;
        res.suggest_edge_ready   = ctl.assist_enable && edge_upd >= ctl.stable_count;
        res.lower_after_climb    = ctl.assist_enable && ctl.auto_lower_enable && climb
                                   && auto_upd >= ctl.stable_count;
        res.lower_after_descend  = ctl.assist_enable && ctl.auto_lower_enable && !climb
                                   && descend_upd >= ctl.stable_count;
        res.saw_high_latched     = high_seen_next;
        res.saw_close_latched    = close_seen_next;
    end

endmodule

/* design/dual_range_sensor_step_judge.sv */
// A tick accepted into the input register is judged into the result register once the latter
// is free (empty, or its result being taken), then offered on result until it transfers.
// Throughput: one tick per cycle while result.ready holds; the input and result registers each
// hold one item, and the tracker and run counters update as a tick enters the result register.
// Reset (rst_n low, asynchronous): both registers empty, frame trackers, run counters and
// latches cleared, configuration back to disabled, climb mode, timeout 500 ms, stable count 1.
`include "dual_range_sensor_step_judge_macros.svh"

module dual_range_sensor_step_judge
    import drssj_pkg::*;
#(
    parameter int RUN_MAX    = 255,
    parameter int TICK_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    drssj_chan_if.sink             sensor,
    drssj_chan_if.source           result
);

    logic                 enable_reg;
    logic                 mode_reg;
    logic                 auto_lower_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [RUN_W-1:0]     stable_reg;
    ctl_t                 ctl;

    logic                 s1_valid_reg;
    in_item_t             s1_item_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;
    logic                 out_free;
    logic                 s1_advance;
    logic                 front_fresh;
    logic                 leg_fresh;
    out_item_t            res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            mode_reg       <= 1'b0;
            auto_lower_reg <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
            stable_reg     <= STABLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ASSIST_ENABLE: enable_reg     <= cfg_data[0];
                CFG_DESCEND_MODE:  mode_reg       <= cfg_data[0];
                CFG_AUTO_LOWER:    auto_lower_reg <= cfg_data[0];
                CFG_STALE_TIMEOUT: timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                CFG_STABLE_COUNT:  stable_reg     <= cfg_data[RUN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        ctl.assist_enable     = enable_reg;
        ctl.descend_mode      = mode_reg;
        ctl.auto_lower_enable = auto_lower_reg;
        ctl.stale_timeout_ms  = timeout_reg;
        ctl.stable_count      = stable_reg;
        // Only a write that actually changes enable or mode restarts progress.
        ctl.clr_progress      = cfg_we
                                && ((cfg_index == CFG_ASSIST_ENABLE && cfg_data[0] != enable_reg)
                                    || (cfg_index == CFG_DESCEND_MODE && cfg_data[0] != mode_reg));
        ctl.clr_lower         = cfg_we && (cfg_index == CFG_AUTO_LOWER);
    end

    assign out_free     = !out_valid_reg || result.ready;
    assign s1_advance   = s1_valid_reg && out_free;
    assign sensor.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (sensor.valid && sensor.ready)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (sensor.valid && sensor.ready)
            s1_item_reg <= sensor.payload;
    end

    drssj_track #(.TICK_WIDTH(TICK_WIDTH)) u_front_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_advance),
        .now     (s1_item_reg.now_ms[TICK_WIDTH-1:0]),
        .valid   (s1_item_reg.front_valid),
        .fault   (s1_item_reg.front_fault),
        .frame   (s1_item_reg.front_frame_num),
        .timeout (timeout_reg),
        .fresh   (front_fresh)
    );

    drssj_track #(.TICK_WIDTH(TICK_WIDTH)) u_leg_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_advance),
        .now     (s1_item_reg.now_ms[TICK_WIDTH-1:0]),
        .valid   (s1_item_reg.leg_valid),
        .fault   (s1_item_reg.leg_fault),
        .frame   (s1_item_reg.leg_frame_num),
        .timeout (timeout_reg),
        .fresh   (leg_fresh)
    );

    drssj_judge #(.RUN_MAX(RUN_MAX)) u_judge (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_advance),
        .ctl         (ctl),
        .front_fresh (front_fresh),
        .leg_fresh   (leg_fresh),
        .front_dist  (s1_item_reg.front_distance_mm),
        .leg_dist    (s1_item_reg.leg_distance_mm),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
            out_item_reg <= res;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    `DRSSJ_ASSERT_NEXT(a_disabled_flags_low, s1_advance && !enable_reg,
        !out_item_reg.suggest_climb && !out_item_reg.suggest_descent
        && !out_item_reg.suggest_edge_ready && !out_item_reg.saw_high_latched
        && !out_item_reg.saw_close_latched, "flag raised while assist is disabled")
    `DRSSJ_ASSERT_NOW(a_mode_exclusive, out_valid_reg,
        !(out_item_reg.suggest_climb && out_item_reg.suggest_descent)
        && !(out_item_reg.lower_after_climb && out_item_reg.lower_after_descend),
        "climb and descend decisions raised together")
    `DRSSJ_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, sensor.ready,
        "input stalled while the result register is empty")
    `DRSSJ_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !s1_advance, s1_valid_reg,
        "input register dropped a tick that did not advance")

endmodule
